// ----- rtl/cob_pkg.sv -----
// Shared types and constants for the cuboid overlap / connecting-box unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package cob_pkg;

  localparam int COORD_BITS = 20;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-2:0] len_t;
  typedef logic        [COORD_BITS-1:0] ext_t;
  typedef logic signed [COORD_BITS:0]   wide_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    len_t   a_len_x;
    len_t   a_len_y;
    len_t   a_len_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    len_t   b_len_x;
    len_t   b_len_y;
    len_t   b_len_z;
  } in_req_t;

  typedef struct packed {
    logic   boxes_overlap;
    logic   link_valid;
    coord_t link_x;
    coord_t link_y;
    coord_t link_z;
    ext_t   link_len_x;
    ext_t   link_len_y;
    ext_t   link_len_z;
  } out_rsp_t;

  typedef struct packed {
    logic   apart;
    logic   ext_zero;
    coord_t start;
    wide_t  ext;
  } axis_res_t;

endpackage

`default_nettype wire

// ----- rtl/cuboid_overlap_or_adjacency_box_unit.sv -----
// Cuboid overlap / connecting-box unit, top level. Depends on cob_pkg and cob_axis.
//
// Use: drive in_req with two boxes (corner Q16.4 plus lengths Q15.4 per axis) and
// raise start; the request is taken at any rising edge with start high and
// busy low. busy is never raised, so a new request may enter every cycle.
// Each request yields exactly one result on out_rsp, marked by out_valid for
// one cycle: out_valid rises once the request has passed the axis stages
// into the result register, and the result is taken at the edge that ends that cycle.
// Throughput is one request per cycle; latency is the three register stages
// of each axis slice (span ends, compares, extent select) plus the result
// register. The three axes run in parallel slices.
// out_rsp reports boxes_overlap and, when link_valid, the connecting box;
// its corner and lengths read zero otherwise.
// Reset clears the stage valid bits only; requests in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module cuboid_overlap_or_adjacency_box_unit
  import cob_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  output out_rsp_t      out_rsp
);

  logic [2:0] vld_r, vld_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_rsp_t   out_rsp_r, out_rsp_nxt;

  axis_res_t  res_x, res_y, res_z;
  logic       apart_any, two_zero, overlap, valid;

  cob_axis u_axis_x (
    .clk (clk), .pa (in_req.a_x), .la (in_req.a_len_x),
    .pb (in_req.b_x), .lb (in_req.b_len_x), .res (res_x)
  );

  cob_axis u_axis_y (
    .clk (clk), .pa (in_req.a_y), .la (in_req.a_len_y),
    .pb (in_req.b_y), .lb (in_req.b_len_y), .res (res_y)
  );

  cob_axis u_axis_z (
    .clk (clk), .pa (in_req.a_z), .la (in_req.a_len_z),
    .pb (in_req.b_z), .lb (in_req.b_len_z), .res (res_z)
  );

  assign busy = 1'b0;

  always_comb begin
    vld_nxt = {vld_r[1:0], start & ~busy};
  end

  always_comb begin
    apart_any = res_x.apart | res_y.apart | res_z.apart;
    two_zero  = (res_x.ext_zero & res_y.ext_zero) | (res_x.ext_zero & res_z.ext_zero) |
                (res_y.ext_zero & res_z.ext_zero);
    overlap   = ~apart_any & ~two_zero;
    valid     = overlap && (res_x.ext != '0) && (res_y.ext != '0) && (res_z.ext != '0);

    out_valid_nxt             = vld_r[2];
    out_rsp_nxt.boxes_overlap = overlap;
    out_rsp_nxt.link_valid    = valid;
    out_rsp_nxt.link_x        = valid ? res_x.start : '0;
    out_rsp_nxt.link_y        = valid ? res_y.start : '0;
    out_rsp_nxt.link_z        = valid ? res_z.start : '0;
    out_rsp_nxt.link_len_x    = valid ? res_x.ext[COORD_BITS-1:0] : '0;
    out_rsp_nxt.link_len_y    = valid ? res_y.ext[COORD_BITS-1:0] : '0;
    out_rsp_nxt.link_len_z    = valid ? res_z.ext[COORD_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

// ----- rtl/cob_axis.sv -----
// One axis of the box pair: three register stages from spans to start and extent.
// Depends on cob_pkg.
`default_nettype none

module cob_axis
  import cob_pkg::*;
(
  input  wire logic      clk,
  input  wire coord_t    pa,
  input  wire len_t      la,
  input  wire coord_t    pb,
  input  wire len_t      lb,
  output axis_res_t      res
);

  // stage 1: span ends
  wide_t  pa_r, pb_r, ea_r, eb_r;
  len_t   la_r, lb_r;
  wide_t  pa_nxt, pb_nxt, ea_nxt, eb_nxt;

  // stage 2: compares and sum
  logic   apart_r, face_a_r, face_b_r;
  coord_t lo_r;
  wide_t  hi_r;
  ext_t   sum_r;
  coord_t pa2_r, pb2_r;
  logic   apart_nxt, face_a_nxt, face_b_nxt;
  coord_t lo_nxt;
  wide_t  hi_nxt;
  ext_t   sum_nxt;
  coord_t pa2_nxt, pb2_nxt;

  // stage 3: result
  axis_res_t res_r, res_nxt;
  wide_t     raw_ext;

  always_comb begin
    pa_nxt = {pa[COORD_BITS-1], pa};
    pb_nxt = {pb[COORD_BITS-1], pb};
    ea_nxt = pa_nxt + $signed({2'b00, la});
    eb_nxt = pb_nxt + $signed({2'b00, lb});
  end

  always_ff @(posedge clk) begin
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
    ea_r <= ea_nxt;
    eb_r <= eb_nxt;
    la_r <= la;
    lb_r <= lb;
  end

  always_comb begin
    apart_nxt  = (pa_r > eb_r) || (pb_r > ea_r);
    lo_nxt     = (pa_r > pb_r) ? pa_r[COORD_BITS-1:0] : pb_r[COORD_BITS-1:0];
    hi_nxt     = (ea_r < eb_r) ? ea_r : eb_r;
    face_a_nxt = (pa_r == eb_r);
    face_b_nxt = (ea_r == pb_r);
    sum_nxt    = {1'b0, la_r} + {1'b0, lb_r};
    pa2_nxt    = pa_r[COORD_BITS-1:0];
    pb2_nxt    = pb_r[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    apart_r  <= apart_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    face_a_r <= face_a_nxt;
    face_b_r <= face_b_nxt;
    sum_r    <= sum_nxt;
    pa2_r    <= pa2_nxt;
    pb2_r    <= pb2_nxt;
  end

  always_comb begin
    raw_ext          = hi_r - {lo_r[COORD_BITS-1], lo_r};
    res_nxt.apart    = apart_r;
    res_nxt.ext_zero = (raw_ext == '0);
    if (face_b_r) begin
      res_nxt.start = pa2_r;
    end else if (face_a_r) begin
      res_nxt.start = pb2_r;
    end else begin
      res_nxt.start = lo_r;
    end
    if (face_a_r || face_b_r) begin
      res_nxt.ext = {1'b0, sum_r};
    end else begin
      res_nxt.ext = raw_ext;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- rtl/cob_checker.sv -----
// Port-level checks for the cuboid overlap unit, bound to the top level.
// Depends on cob_pkg and cuboid_overlap_or_adjacency_box_unit.
`default_nettype none

module cob_checker
  import cob_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire out_rsp_t out_rsp
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without request four cycles earlier");

  a_link_needs_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.link_valid) |-> out_rsp.boxes_overlap)
    else $error("link valid without overlap");

  a_invalid_link_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.link_valid) |->
      (out_rsp.link_x == '0 && out_rsp.link_y == '0 && out_rsp.link_z == '0 &&
       out_rsp.link_len_x == '0 && out_rsp.link_len_y == '0 &&
       out_rsp.link_len_z == '0))
    else $error("invalid link carries nonzero fields");

  a_valid_link_volume: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.link_valid) |->
      (out_rsp.link_len_x != '0 && out_rsp.link_len_y != '0 &&
       out_rsp.link_len_z != '0))
    else $error("valid link with zero length");

endmodule

bind cuboid_overlap_or_adjacency_box_unit cob_checker u_cob_checker (.*);

`default_nettype wire
